// ===== sv/regulator_voltage_selector_convert_assert.svh =====
// Assertion macros for the regulator selector converter checker.
// Depends on nothing; the including module supplies clk and rst_n.
`ifndef REGULATOR_VOLTAGE_SELECTOR_CONVERT_ASSERT_SVH
`define REGULATOR_VOLTAGE_SELECTOR_CONVERT_ASSERT_SVH

// Clocked assertion that is switched off while reset is held.
`define RVSC_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that is also checked during reset.
`define RVSC_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/rvsc_pkg.sv =====
// Shared constants and pipeline payload types for the regulator selector converter.
// No dependencies.
`default_nettype none

package rvsc_pkg;

  // Operation codes.
  localparam logic OP_TO_VALUE = 1'b0;
  localparam logic OP_TO_RAW   = 1'b1;

  // Result status codes.
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_RANGE = 2'd1;
  localparam logic [1:0] ST_OVF   = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_MIN_VALUE          = 3'd0;
  localparam logic [2:0] REG_MAX_VALUE          = 3'd1;
  localparam logic [2:0] REG_FIRST_START_RAW    = 3'd2;
  localparam logic [2:0] REG_FIRST_START_VALUE  = 3'd3;
  localparam logic [2:0] REG_FIRST_STEP         = 3'd4;
  localparam logic [2:0] REG_SECOND_START_RAW   = 3'd5;
  localparam logic [2:0] REG_SECOND_START_VALUE = 3'd6;
  localparam logic [2:0] REG_SECOND_STEP        = 3'd7;

  // Dividend width of the floor division, one quotient bit per stage.
  localparam int DIV_BITS = 17;
  // Select, multiply, prepare, divide, sign fix and output stages.
  localparam int NUM_STG  = DIV_BITS + 5;
  localparam int STG_A    = 0;
  localparam int STG_B    = 1;
  localparam int STG_DV0  = 2;
  localparam int STG_E    = STG_DV0 + DIV_BITS + 1;
  localparam int STG_OUT  = STG_E + 1;

  typedef struct packed {
    logic        op;
    logic [1:0]  status;
    logic [7:0]  s_raw;
    logic [15:0] s_val;
    logic [15:0] step;
    logic [15:0] diff;
    logic [15:0] val;
  } a_t;

  typedef struct packed {
    logic               op;
    logic [1:0]         status;
    logic [7:0]         s_raw;
    logic [15:0]        s_val;
    logic [15:0]        step;
    logic [15:0]        prod;
    logic signed [17:0] num;
  } b_t;

  typedef struct packed {
    logic                op;
    logic [1:0]          status;
    logic [15:0]         val_out;
    logic [7:0]          s_raw;
    logic                neg;
    logic [15:0]         step;
    logic [15:0]         rem;
    logic [DIV_BITS-1:0] dvd;
    logic [DIV_BITS-1:0] quo;
  } dv_t;

  typedef struct packed {
    logic               op;
    logic [1:0]         status;
    logic [15:0]        val_out;
    logic [7:0]         s_raw;
    logic signed [17:0] qs;
  } e_t;

  typedef struct packed {
    logic [15:0] value_out;
    logic [7:0]  raw_out;
    logic [1:0]  status;
  } o_t;

endpackage

`default_nettype wire

// ===== sv/regulator_voltage_selector_convert.sv =====
// Regulator selector converter: range select, multiply and pipelined floor divider.
// Depends on rvsc_pkg.
//
// Usage: a request on the in_ channel (valid/ready) carries in_operation, in_raw_in and
// in_value_in. Operation 0 maps a raw selector code to its cooked value; operation 1
// checks a value against min/max and maps it to the nearest raw code, flagging codes
// outside 0..255. Each request yields exactly one result on the out_ channel.
// The eight range registers are written through cfg_wr_en/cfg_index/cfg_data while
// no request is in flight; a write takes effect at the next edge.
// The datapath is 22 register stages: range select, 16x16 multiply, dividend
// preparation, 17 restoring divider stages (one quotient bit each), sign fix and the
// output register. One request is taken every cycle while the receiver keeps
// out_ready high.
// Each stage holds a valid bit and advances when the stage ahead is empty or moving,
// so bubbles close up and a request is still taken while a result waits. When the
// receiver stalls long enough the pipeline fills and in_ready falls.
// Synchronous reset clears all valid bits and loads the register reset values.
`default_nettype none

module regulator_voltage_selector_convert
  import rvsc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_operation,
  input  wire logic [7:0]  in_raw_in,
  input  wire logic [15:0] in_value_in,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      out_value_out,
  output logic [7:0]       out_raw_out,
  output logic [1:0]       out_status,
  input  wire logic        cfg_wr_en,
  input  wire logic [2:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  logic [15:0] min_value_r, max_value_r;
  logic [7:0]  first_start_raw_r, second_start_raw_r;
  logic [15:0] first_start_value_r, second_start_value_r;
  logic [15:0] first_step_r, second_step_r;

  logic [NUM_STG-1:0] v_r, v_nxt, en;

  a_t  a_r, a_nxt;
  b_t  b_r, b_nxt;
  dv_t dv_r   [0:DIV_BITS];
  dv_t dv_nxt [0:DIV_BITS];
  e_t  e_r, e_nxt;
  o_t  o_r, o_nxt;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_value_r          <= 16'd0;
      max_value_r          <= 16'hFFFF;
      first_start_raw_r    <= 8'd0;
      first_start_value_r  <= 16'd0;
      first_step_r         <= 16'd1;
      second_start_raw_r   <= 8'd0;
      second_start_value_r <= 16'd0;
      second_step_r        <= 16'd0;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_MIN_VALUE:          min_value_r          <= cfg_data;
        REG_MAX_VALUE:          max_value_r          <= cfg_data;
        REG_FIRST_START_RAW:    first_start_raw_r    <= cfg_data[7:0];
        REG_FIRST_START_VALUE:  first_start_value_r  <= cfg_data;
        REG_FIRST_STEP:         first_step_r         <= cfg_data;
        REG_SECOND_START_RAW:   second_start_raw_r   <= cfg_data[7:0];
        REG_SECOND_START_VALUE: second_start_value_r <= cfg_data;
        REG_SECOND_STEP:        second_step_r        <= cfg_data;
        default: ;
      endcase
    end
  end

  // A stage may load when it is empty or when the stage ahead of it loads.
  always_comb begin
    en[NUM_STG-1] = !v_r[NUM_STG-1] || out_ready;
    for (int k = NUM_STG - 2; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end

  always_comb begin
    v_nxt[0] = en[0] ? in_valid : v_r[0];
    for (int k = 1; k < NUM_STG; k++) begin
      v_nxt[k] = en[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  assign in_ready  = en[STG_A];
  assign out_valid = v_r[STG_OUT];

  // Stage A: range selection and the out-of-range check.
  always_comb begin
    logic second;
    second = (second_step_r != 16'd0) &&
             ((in_operation == OP_TO_VALUE) ? (in_raw_in >= second_start_raw_r)
                                            : (in_value_in >= second_start_value_r));
    a_nxt.op     = in_operation;
    a_nxt.s_raw  = second ? second_start_raw_r   : first_start_raw_r;
    a_nxt.s_val  = second ? second_start_value_r : first_start_value_r;
    a_nxt.step   = second ? second_step_r        : first_step_r;
    a_nxt.diff   = 16'(in_raw_in) - 16'(a_nxt.s_raw);
    a_nxt.val    = in_value_in;
    a_nxt.status = ((in_operation == OP_TO_RAW) &&
                    ((in_value_in < min_value_r) || (in_value_in > max_value_r)))
                   ? ST_RANGE : ST_OK;
  end

  always_ff @(posedge clk) begin
    if (en[STG_A]) begin
      a_r <= a_nxt;
    end
  end

  // Stage B: code offset times step, and the rounded numerator for the division.
  always_comb begin
    logic [15:0] full;
    full         = a_r.diff * a_r.step;
    b_nxt.op     = a_r.op;
    b_nxt.status = a_r.status;
    b_nxt.s_raw  = a_r.s_raw;
    b_nxt.s_val  = a_r.s_val;
    b_nxt.step   = a_r.step;
    b_nxt.prod   = full;
    b_nxt.num    = $signed({2'b00, a_r.val}) - $signed({2'b00, a_r.s_val})
                 + $signed({3'b000, a_r.step[15:1]});
  end

  always_ff @(posedge clk) begin
    if (en[STG_B]) begin
      b_r <= b_nxt;
    end
  end

  // Stage C: floor of a negative quotient is the negated ceiling of its magnitude,
  // so a negative numerator is turned into |n| + step - 1.
  always_comb begin
    logic [17:0] neg_num;
    neg_num          = 18'(-b_r.num);
    dv_nxt[0].op      = b_r.op;
    dv_nxt[0].val_out = b_r.s_val + b_r.prod;
    dv_nxt[0].s_raw   = b_r.s_raw;
    dv_nxt[0].neg     = b_r.num[17];
    dv_nxt[0].step    = b_r.step;
    dv_nxt[0].rem     = 16'd0;
    dv_nxt[0].quo     = '0;
    dv_nxt[0].dvd     = b_r.num[17]
                        ? (neg_num[DIV_BITS-1:0] + DIV_BITS'(b_r.step) - DIV_BITS'(1))
                        : b_r.num[DIV_BITS-1:0];
    dv_nxt[0].status  = b_r.status;
    if ((b_r.op == OP_TO_RAW) && (b_r.status == ST_OK) && (b_r.step == 16'd0)) begin
      dv_nxt[0].status = ST_OVF;
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_DV0]) begin
      dv_r[0] <= dv_nxt[0];
    end
  end

  // Restoring divider, one quotient bit per stage, most significant first.
  for (genvar j = 1; j <= DIV_BITS; j++) begin : g_div
    always_comb begin
      logic [16:0] trial;
      logic        ge;
      trial          = {dv_r[j-1].rem, dv_r[j-1].dvd[DIV_BITS-1]};
      ge             = trial >= {1'b0, dv_r[j-1].step};
      dv_nxt[j]      = dv_r[j-1];
      dv_nxt[j].rem  = ge ? 16'(trial - {1'b0, dv_r[j-1].step}) : trial[15:0];
      dv_nxt[j].dvd  = {dv_r[j-1].dvd[DIV_BITS-2:0], 1'b0};
      dv_nxt[j].quo  = {dv_r[j-1].quo[DIV_BITS-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (en[STG_DV0 + j]) begin
        dv_r[j] <= dv_nxt[j];
      end
    end
  end

  // Stage E: restore the quotient sign.
  always_comb begin
    logic [17:0] mag;
    mag           = {1'b0, dv_r[DIV_BITS].quo};
    e_nxt.op      = dv_r[DIV_BITS].op;
    e_nxt.status  = dv_r[DIV_BITS].status;
    e_nxt.val_out = dv_r[DIV_BITS].val_out;
    e_nxt.s_raw   = dv_r[DIV_BITS].s_raw;
    e_nxt.qs      = dv_r[DIV_BITS].neg ? $signed(-mag) : $signed(mag);
  end

  always_ff @(posedge clk) begin
    if (en[STG_E]) begin
      e_r <= e_nxt;
    end
  end

  // Output stage: add the range start code and check that it fits in eight bits.
  always_comb begin
    logic [18:0] code;
    code            = 19'({e_r.qs[17], e_r.qs}) + 19'(e_r.s_raw);
    o_nxt.value_out = 16'd0;
    o_nxt.raw_out   = 8'd0;
    o_nxt.status    = e_r.status;
    if (e_r.op == OP_TO_VALUE) begin
      o_nxt.value_out = e_r.val_out;
      o_nxt.status    = ST_OK;
    end else if (e_r.status == ST_OK) begin
      if (code[18:8] == 11'd0) begin
        o_nxt.raw_out = code[7:0];
      end else begin
        o_nxt.status  = ST_OVF;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[STG_OUT]) begin
      o_r <= o_nxt;
    end
  end

  assign out_value_out = o_r.value_out;
  assign out_raw_out   = o_r.raw_out;
  assign out_status    = o_r.status;

endmodule

`default_nettype wire

// ===== sv/rvsc_checker.sv =====
// Port-level checker for the regulator selector converter, bound to the top level.
// Depends on rvsc_pkg and regulator_voltage_selector_convert_assert.svh.
`default_nettype none

`include "regulator_voltage_selector_convert_assert.svh"

module rvsc_checker
  import rvsc_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [15:0] out_value_out,
  input wire logic [7:0]  out_raw_out,
  input wire logic [1:0]  out_status
);

  // A stalled result must hold until the receiver takes it.
  `RVSC_ASSERT(a_out_hold,
    out_valid && !out_ready |=> out_valid && $stable(out_value_out) &&
    $stable(out_raw_out) && $stable(out_status),
    "result changed while stalled")

  // Any failed conversion reports a zero raw code and a zero value.
  `RVSC_ASSERT(a_err_zero_raw,
    out_valid && (out_status != ST_OK) |-> (out_raw_out == 8'd0) &&
    (out_value_out == 16'd0),
    "error result carries data")

  // Only one of the two result fields can be nonzero for one request.
  `RVSC_ASSERT(a_one_field,
    out_valid && (out_raw_out != 8'd0) |-> (out_value_out == 16'd0) &&
    (out_status == ST_OK),
    "raw and value both set")

  // Reset empties the pipeline.
  `RVSC_ASSERT_ALWAYS(a_reset_empty, !rst_n |=> !out_valid, "result valid after reset")

endmodule

bind regulator_voltage_selector_convert rvsc_checker u_rvsc_checker (.*);

`default_nettype wire

// ===== tb/sv/regulator_voltage_selector_convert_checker.sv =====
// Checker for the regulator selector converter: follows register writes, predicts the
// result of every accepted request and compares it with what the out_ channel returns.
// Depends on rvsc_pkg for the operation, status and register index codes.
module regulator_voltage_selector_convert_checker
  import rvsc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        in_operation,
  input  logic [7:0]  in_raw_in,
  input  logic [15:0] in_value_in,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic [15:0] out_value_out,
  input  logic [7:0]  out_raw_out,
  input  logic [1:0]  out_status,
  input  logic        cfg_wr_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data,
  output int          mismatch_count,
  output int          results_owed
);

  typedef struct packed {
    logic [15:0] value_out;
    logic [7:0]  raw_out;
    logic [1:0]  status;
  } conversion_t;

  // Local copy of the range registers.
  logic [15:0] min_val, max_val;
  logic [7:0]  lo_start_raw, hi_start_raw;
  logic [15:0] lo_start_val, hi_start_val;
  logic [15:0] lo_step, hi_step;

  conversion_t owed_q[$];
  int          errors = 0;

  initial begin
    mismatch_count = 0;
    results_owed = 0;
  end

  function automatic conversion_t convert_request(logic op, logic [7:0] raw, logic [15:0] val);
    conversion_t r;
    logic        use_hi;
    logic [7:0]  base_raw;
    logic [15:0] base_val, step, offset;
    longint      num, quo, code;
    r = '{value_out: 16'd0, raw_out: 8'd0, status: ST_OK};
    if (op == OP_TO_VALUE) begin
      use_hi = (hi_step != 16'd0) && (raw >= hi_start_raw);
      base_raw = use_hi ? hi_start_raw : lo_start_raw;
      base_val = use_hi ? hi_start_val : lo_start_val;
      step = use_hi ? hi_step : lo_step;
      // A code below the range start wraps; the product is kept modulo 2^16.
      offset = 16'(raw) - 16'(base_raw);
      r.value_out = base_val + offset * step;
    end else if (val < min_val || val > max_val) begin
      r.status = ST_RANGE;
    end else begin
      use_hi = (hi_step != 16'd0) && (val >= hi_start_val);
      base_raw = use_hi ? hi_start_raw : lo_start_raw;
      base_val = use_hi ? hi_start_val : lo_start_val;
      step = use_hi ? hi_step : lo_step;
      if (step == 16'd0) begin
        r.status = ST_OVF;
      end else begin
        // Round to nearest by adding half a step, then divide rounding toward minus infinity.
        num = longint'(val) - longint'(base_val) + longint'(step / 16'd2);
        quo = num / longint'(step);
        if ((num % longint'(step)) != 0 && num < 0) quo = quo - 1;
        code = quo + longint'(base_raw);
        if (code < 0 || code > 255) r.status = ST_OVF;
        else r.raw_out = code[7:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    conversion_t want;
    if (!rst_n) begin
      min_val = 16'd0;
      max_val = 16'hFFFF;
      lo_start_raw = 8'd0;
      lo_start_val = 16'd0;
      lo_step = 16'd1;
      hi_start_raw = 8'd0;
      hi_start_val = 16'd0;
      hi_step = 16'd0;
      owed_q.delete();
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          REG_MIN_VALUE:          min_val = cfg_data;
          REG_MAX_VALUE:          max_val = cfg_data;
          REG_FIRST_START_RAW:    lo_start_raw = cfg_data[7:0];
          REG_FIRST_START_VALUE:  lo_start_val = cfg_data;
          REG_FIRST_STEP:         lo_step = cfg_data;
          REG_SECOND_START_RAW:   hi_start_raw = cfg_data[7:0];
          REG_SECOND_START_VALUE: hi_start_val = cfg_data;
          REG_SECOND_STEP:        hi_step = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (owed_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual value_out %h raw_out %h status %0d",
                   $time, out_value_out, out_raw_out, out_status);
          errors++;
        end else begin
          want = owed_q.pop_front();
          if (out_value_out !== want.value_out) begin
            $display("%0t: value_out expected %h actual %h", $time, want.value_out, out_value_out);
            errors++;
          end
          if (out_raw_out !== want.raw_out) begin
            $display("%0t: raw_out expected %h actual %h", $time, want.raw_out, out_raw_out);
            errors++;
          end
          if (out_status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, out_status);
            errors++;
          end
        end
      end
      if (in_valid && in_ready)
        owed_q.push_back(convert_request(in_operation, in_raw_in, in_value_in));
    end
    mismatch_count <= errors;
    results_owed <= owed_q.size();
  end

endmodule

// ===== tb/sv/tb_regulator_voltage_selector_convert.sv =====
// Top of the regulator selector converter testbench: clock, reset, range settings and
// request stimulus with random gaps on both channels, plus the watchdog and the verdict.
// Depends on rvsc_pkg, the converter and regulator_voltage_selector_convert_checker.
module tb_regulator_voltage_selector_convert;
  import rvsc_pkg::*;

  localparam int LATENCY_PAD    = 30;
  localparam int STALL_LIMIT    = 2000;
  localparam int RANDOM_PHASES  = 6;
  localparam int REQS_PER_PHASE = 125;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_operation = 1'b0;
  logic [7:0]  in_raw_in = 8'd0;
  logic [15:0] in_value_in = 16'd0;
  logic        out_ready = 1'b0;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = 3'd0;
  logic [15:0] cfg_data = 16'd0;
  logic        in_ready, out_valid;
  logic [15:0] out_value_out;
  logic [7:0]  out_raw_out;
  logic [1:0]  out_status;
  int          mismatch_count, results_owed;

  int rx_gap = 0;
  int idle_cycles = 0;
  bit no_gaps = 1'b0;

  // Settings currently loaded, used only to aim requests at the interesting values.
  logic [15:0] cur_min = 16'd0, cur_max = 16'hFFFF;
  logic [7:0]  cur_lo_raw = 8'd0, cur_hi_raw = 8'd0;
  logic [15:0] cur_lo_val = 16'd0, cur_hi_val = 16'd0, cur_hi_step = 16'd0;

  always #10 clk = ~clk;

  regulator_voltage_selector_convert i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_raw_in(in_raw_in), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_value_out(out_value_out),
    .out_raw_out(out_raw_out), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  regulator_voltage_selector_convert_checker i_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_operation(in_operation),
    .in_raw_in(in_raw_in), .in_value_in(in_value_in),
    .out_valid(out_valid), .out_ready(out_ready), .out_value_out(out_value_out),
    .out_raw_out(out_raw_out), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .mismatch_count(mismatch_count), .results_owed(results_owed)
  );

  // Receiver: after each result it may hold out_ready low before taking the next one.
  always @(posedge clk) begin : receiver
    int gap;
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_gap <= 0;
    end else if (out_valid && out_ready) begin
      gap = no_gaps ? 0 : $urandom_range(0, 5);
      out_ready <= (gap == 0);
      rx_gap <= gap;
    end else if (rx_gap > 0) begin
      out_ready <= (rx_gap == 1);
      rx_gap <= rx_gap - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb_regulator_voltage_selector_convert NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic write_reg(input logic [2:0] idx, input int data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data[15:0];
    @(posedge clk);
  endtask

  task automatic load_ranges(input int min_v, input int max_v, input int lo_raw,
                             input int lo_val, input int lo_step, input int hi_raw,
                             input int hi_val, input int hi_step);
    write_reg(REG_MIN_VALUE, min_v);
    write_reg(REG_MAX_VALUE, max_v);
    write_reg(REG_FIRST_START_RAW, lo_raw);
    write_reg(REG_FIRST_START_VALUE, lo_val);
    write_reg(REG_FIRST_STEP, lo_step);
    write_reg(REG_SECOND_START_RAW, hi_raw);
    write_reg(REG_SECOND_START_VALUE, hi_val);
    write_reg(REG_SECOND_STEP, hi_step);
    cfg_wr_en <= 1'b0;
    cur_min = min_v[15:0];
    cur_max = max_v[15:0];
    cur_lo_raw = lo_raw[7:0];
    cur_lo_val = lo_val[15:0];
    cur_hi_raw = hi_raw[7:0];
    cur_hi_val = hi_val[15:0];
    cur_hi_step = hi_step[15:0];
  endtask

  // Returns at the edge that accepts the request.
  task automatic send(input logic op, input logic [7:0] raw, input logic [15:0] val);
    int gap;
    gap = no_gaps ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_raw_in <= raw;
    in_value_in <= val;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_owed != 0) @(posedge clk);
    repeat (LATENCY_PAD) @(posedge clk);
  endtask

  task automatic random_ranges(input bit wild);
    int min_v, max_v, lo_raw, lo_val, lo_step, hi_raw, hi_val, hi_step;
    if (wild) begin
      min_v = $urandom_range(0, 65535);
      max_v = $urandom_range(0, 65535);
      lo_raw = $urandom_range(0, 255);
      lo_val = $urandom_range(0, 65535);
      lo_step = $urandom_range(1, 65535);
      hi_raw = $urandom_range(0, 255);
      hi_val = $urandom_range(0, 65535);
      hi_step = $urandom_range(0, 65535);
    end else begin
      // Two contiguous ranges covering the code space, the usual regulator layout.
      lo_step = $urandom_range(1, 120);
      lo_raw = $urandom_range(0, 64);
      lo_val = $urandom_range(0, 30000);
      hi_raw = lo_raw + $urandom_range(1, 191);
      hi_val = lo_val + (hi_raw - lo_raw) * lo_step;
      hi_step = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 250);
      min_v = lo_val - $urandom_range(0, 60);
      if (min_v < 0) min_v = 0;
      max_v = hi_val + (255 - hi_raw) * hi_step + $urandom_range(0, 60);
      if (max_v > 65535) max_v = 65535;
    end
    load_ranges(min_v, max_v, lo_raw, lo_val, lo_step, hi_raw, hi_val, hi_step);
  endtask

  function automatic logic [15:0] pick_value();
    case ($urandom_range(0, 9))
      0, 1: return 16'($urandom_range(0, 65535));
      2: begin
        case ($urandom_range(0, 6))
          0: return cur_min - 16'd1;
          1: return cur_min;
          2: return cur_max;
          3: return cur_max + 16'd1;
          4: return cur_hi_val - 16'd1;
          5: return cur_hi_val;
          default: return cur_lo_val;
        endcase
      end
      default: return 16'($urandom_range(cur_min, cur_max));
    endcase
  endfunction

  function automatic logic [7:0] pick_raw();
    case ($urandom_range(0, 9))
      0: return cur_lo_raw - 8'd1;
      1: return cur_lo_raw;
      2: return cur_hi_raw - 8'd1;
      3: return cur_hi_raw;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Reset settings: identity mapping, so values above 255 overflow the code.
    send(OP_TO_VALUE, 8'd0, 16'd0);
    send(OP_TO_VALUE, 8'd255, 16'hFFFF);
    send(OP_TO_RAW, 8'd0, 16'd0);
    send(OP_TO_RAW, 8'd0, 16'd255);
    send(OP_TO_RAW, 8'd0, 16'd256);
    send(OP_TO_RAW, 8'hFF, 16'hFFFF);
    drain_results();

    // Two ranges, with the minimum below the first range start so that values below
    // the start floor to a smaller code or to a negative one.
    load_ranges(300, 3300, 10, 600, 25, 58, 1800, 50);
    send(OP_TO_VALUE, 8'd0, 16'd0);
    send(OP_TO_VALUE, 8'd10, 16'd0);
    send(OP_TO_VALUE, 8'd57, 16'd0);
    send(OP_TO_VALUE, 8'd58, 16'd0);
    send(OP_TO_VALUE, 8'd255, 16'd0);
    send(OP_TO_RAW, 8'd0, 16'd299);
    send(OP_TO_RAW, 8'd0, 16'd3301);
    send(OP_TO_RAW, 8'd0, 16'd300);
    send(OP_TO_RAW, 8'd0, 16'd500);
    send(OP_TO_RAW, 8'd0, 16'd612);
    send(OP_TO_RAW, 8'd0, 16'd613);
    send(OP_TO_RAW, 8'd0, 16'd1799);
    send(OP_TO_RAW, 8'd0, 16'd1800);
    send(OP_TO_RAW, 8'd0, 16'd3300);
    drain_results();

    // Register extremes with the minimum above the maximum.
    load_ranges(65535, 0, 255, 65535, 65535, 255, 65535, 65535);
    send(OP_TO_VALUE, 8'd0, 16'd0);
    send(OP_TO_VALUE, 8'd255, 16'd0);
    send(OP_TO_RAW, 8'd0, 16'd0);
    send(OP_TO_RAW, 8'd0, 16'hFFFF);
    drain_results();

    // A zero first step leaves no code to compute for values in the first range.
    load_ranges(0, 65535, 0, 100, 0, 0, 0, 0);
    send(OP_TO_VALUE, 8'd7, 16'd0);
    send(OP_TO_RAW, 8'd0, 16'd0);
    send(OP_TO_RAW, 8'd0, 16'hFFFF);
    drain_results();

    for (int p = 0; p < RANDOM_PHASES; p++) begin
      no_gaps = (p == 2);
      random_ranges(p == 4);
      for (int k = 0; k < REQS_PER_PHASE; k++) begin
        if ($urandom_range(0, 1) == 0) begin
          send(OP_TO_VALUE, pick_raw(), 16'($urandom_range(0, 65535)));
        end else begin
          send(OP_TO_RAW, 8'($urandom_range(0, 255)), pick_value());
        end
        // Let the pipeline run empty now and then before the next request.
        if ((p == 1 && k == 60) || $urandom_range(0, 199) == 0) drain_results();
      end
      drain_results();
    end

    if (mismatch_count == 0 && results_owed == 0)
      $display("tb_regulator_voltage_selector_convert OK");
    else
      $display("tb_regulator_voltage_selector_convert NOT OK");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+sv
sv/rvsc_pkg.sv
sv/regulator_voltage_selector_convert.sv
sv/rvsc_checker.sv
tb/sv/regulator_voltage_selector_convert_checker.sv
tb/sv/tb_regulator_voltage_selector_convert.sv
